[sv/assert_macros.svh]
// assertion helpers, clocked on clk with active-low rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ocagg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocagg_pkg
// shared widths, codes and defaults of the candle aggregator
// ----------------------------------------------------------------------------
package ocagg_pkg;

    localparam int TIME_W  = 44;
    localparam int PRICE_W = 32;
    localparam int SIZE_W  = 32;
    localparam int VOL_W   = 48;
    localparam int IV_W    = 32;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam int DEF_MAX_FILL = 63;

    localparam logic [IV_W-1:0] IV_RESET = 32'd60000;

    localparam logic OP_TRADE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic ACT_APPEND  = 1'b0;
    localparam logic ACT_REPLACE = 1'b1;

    // register index taken from byte address bit 2
    localparam logic REG_INTERVAL = 1'b0;

endpackage

[sv/ocagg_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocagg_div
// restoring divider, one quotient bit per cycle, time word by interval
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ocagg_div
    import ocagg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TIME_W-1:0] dividend,
    input  logic [IV_W-1:0]   divisor,
    output logic              done,
    output logic [TIME_W-1:0] quotient,
    output logic [IV_W-1:0]   remainder
);

    localparam int CNT_W = $clog2(TIME_W);

    logic [TIME_W-1:0] quot_reg;
    logic [IV_W-1:0]   rem_reg;
    logic [IV_W-1:0]   div_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [IV_W:0] trial;
    logic [IV_W:0] diff;
    logic          ge;

    assign trial = {rem_reg, quot_reg[TIME_W-1]};
    assign ge    = (trial >= {1'b0, div_reg});
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(TIME_W - 1);
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[TIME_W-2:0], ge};
            rem_reg  <= ge ? diff[IV_W-1:0] : trial[IV_W-1:0];
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

    `ASSERT_NEXT(a_start_busy, start, busy_reg && !done_reg, "divider did not start")
    `ASSERT_IMPL(a_done_idle, done_reg, !busy_reg, "divider done while busy")

endmodule

[sv/ohlcv_candle_aggregator.sv]
`timescale 1ns / 1ps
// a trade in a new first or current bucket gives a single result;
// a later bucket adds a second divide and the multiply and base steps,
// then one result per cycle while the output is not stalled
// one item at a time: the one-bit-per-cycle divider runs once or twice per item
// reset: interval_ms 60000, candle state and tick time cleared, no memories
// ----------------------------------------------------------------------------
// ohlcv_candle_aggregator
// builds ohlcv candles from trades and book ticks, with flat gap filling
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ohlcv_candle_aggregator
    import ocagg_pkg::*;
#(
    parameter int MAX_FILL = DEF_MAX_FILL
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic [TIME_W-1:0]  event_time_ms,
    input  logic [PRICE_W-1:0] trade_price,
    input  logic [SIZE_W-1:0]  trade_size,

    output logic               out_valid,
    input  logic               out_stall,
    output logic               action,
    output logic [TIME_W-1:0]  bucket_start_ms,
    output logic [PRICE_W-1:0] open_price,
    output logic [PRICE_W-1:0] high_price,
    output logic [PRICE_W-1:0] low_price,
    output logic [PRICE_W-1:0] close_price,
    output logic [VOL_W-1:0]   volume_total,
    output logic               last_of_run,
    output logic               gap_skipped
);

    localparam int CNT_W  = $clog2(MAX_FILL + 1);
    localparam int PROD_W = CNT_W + IV_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV1,
        S_DECIDE,
        S_DIV2,
        S_MUL,
        S_BASE,
        S_EMIT
    } state_t;

    state_t state_reg;

    // configuration
    logic [IV_W-1:0] interval_reg;
    logic [IV_W-1:0] iv_eff;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_INTERVAL);
    assign prdata = (paddr[2] == REG_INTERVAL) ? interval_reg : '0;
    assign iv_eff = (interval_reg == '0) ? IV_W'(1) : interval_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            interval_reg <= IV_RESET;
        else if (cfg_wr)
            interval_reg <= pwdata;
    end

    // candle state
    logic               started_reg;
    logic [TIME_W-1:0]  bucket_start_reg;
    logic [PRICE_W-1:0] open_reg;
    logic [PRICE_W-1:0] high_reg;
    logic [PRICE_W-1:0] low_reg;
    logic [PRICE_W-1:0] close_reg;
    logic [VOL_W-1:0]   volume_reg;
    logic [TIME_W-1:0]  last_tick_reg;

    // item and run registers
    logic               op_reg;
    logic [TIME_W-1:0]  t_reg;
    logic [PRICE_W-1:0] price_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [TIME_W-1:0]  target_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               skip_reg;
    logic               final_act_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [TIME_W-1:0]  cur_time_reg;
    logic [PRICE_W-1:0] flat_reg;

    // divider
    logic              div_start_reg;
    logic [TIME_W-1:0] div_arg_reg;
    logic              div_done;
    logic [TIME_W-1:0] div_quot;
    logic [IV_W-1:0]   div_rem;

    ocagg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .dividend  (div_arg_reg),
        .divisor   (iv_eff),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // output register
    logic               out_valid_reg;
    logic               act_out_reg;
    logic [TIME_W-1:0]  time_out_reg;
    logic [PRICE_W-1:0] open_out_reg;
    logic [PRICE_W-1:0] high_out_reg;
    logic [PRICE_W-1:0] low_out_reg;
    logic [PRICE_W-1:0] close_out_reg;
    logic [VOL_W-1:0]   vol_out_reg;
    logic               last_out_reg;
    logic               skip_out_reg;

    // helpers
    logic [TIME_W-1:0] gap_d;
    logic [TIME_W-1:0] cq;
    logic [VOL_W:0]    vol_sum;
    logic [VOL_W-1:0]  vol_next;
    logic              slot_free;
    logic              tick_new;
    logic              same_bucket;

    assign gap_d       = target_reg - bucket_start_reg;
    assign cq          = div_quot + TIME_W'(div_rem != '0);
    assign vol_sum     = {1'b0, volume_reg} + (VOL_W + 1)'(size_reg);
    assign vol_next    = vol_sum[VOL_W] ? {VOL_W{1'b1}} : vol_sum[VOL_W-1:0];
    assign slot_free   = !out_valid_reg || !out_stall;
    assign tick_new    = (t_reg > last_tick_reg);
    assign same_bucket = (target_reg == bucket_start_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            started_reg      <= 1'b0;
            bucket_start_reg <= '0;
            open_reg         <= '0;
            high_reg         <= '0;
            low_reg          <= '0;
            close_reg        <= '0;
            volume_reg       <= '0;
            last_tick_reg    <= '0;
            div_start_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
            cnt_reg          <= '0;
            fill_reg         <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != S_EMIT))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg        <= opcode;
                        t_reg         <= event_time_ms;
                        price_reg     <= trade_price;
                        size_reg      <= trade_size;
                        div_arg_reg   <= event_time_ms;
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV1;
                    end
                end
                S_DIV1:
                begin
                    div_start_reg <= 1'b0;
                    if (div_done)
                    begin
                        target_reg <= t_reg - TIME_W'(div_rem);
                        state_reg  <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    cnt_reg       <= '0;
                    fill_reg      <= '0;
                    skip_reg      <= 1'b0;
                    final_act_reg <= (op_reg == OP_TRADE && started_reg && same_bucket)
                                     ? ACT_REPLACE : ACT_APPEND;
                    if (op_reg == OP_TICK)
                    begin
                        if (tick_new)
                            last_tick_reg <= t_reg;
                        if (tick_new && started_reg && (target_reg > bucket_start_reg))
                        begin
                            div_arg_reg   <= gap_d;
                            div_start_reg <= 1'b1;
                            state_reg     <= S_DIV2;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else if (!started_reg)
                    begin
                        started_reg      <= 1'b1;
                        bucket_start_reg <= target_reg;
                        open_reg         <= price_reg;
                        high_reg         <= price_reg;
                        low_reg          <= price_reg;
                        close_reg        <= price_reg;
                        volume_reg       <= VOL_W'(size_reg);
                        state_reg        <= S_EMIT;
                    end
                    else if (same_bucket)
                    begin
                        if (price_reg > high_reg)
                            high_reg <= price_reg;
                        if (price_reg < low_reg)
                            low_reg <= price_reg;
                        close_reg  <= price_reg;
                        volume_reg <= vol_next;
                        state_reg  <= S_EMIT;
                    end
                    else if (target_reg > bucket_start_reg)
                    begin
                        div_arg_reg   <= gap_d;
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV2;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_DIV2:
                begin
                    div_start_reg <= 1'b0;
                    if (div_done)
                    begin
                        // fillers before the final candle of the run
                        if (op_reg == OP_TICK)
                        begin
                            skip_reg <= (cq > TIME_W'(MAX_FILL));
                            fill_reg <= (cq > TIME_W'(MAX_FILL)) ? CNT_W'(MAX_FILL - 1)
                                                                 : CNT_W'(cq - 1'b1);
                        end
                        else
                        begin
                            skip_reg <= (cq > TIME_W'(MAX_FILL + 1));
                            fill_reg <= (cq > TIME_W'(MAX_FILL + 1)) ? CNT_W'(MAX_FILL)
                                                                     : CNT_W'(cq - 1'b1);
                        end
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= PROD_W'(fill_reg) * PROD_W'(iv_eff);
                    state_reg <= S_BASE;
                end
                S_BASE:
                begin
                    cur_time_reg     <= target_reg - TIME_W'(prod_reg);
                    flat_reg         <= close_reg;
                    bucket_start_reg <= target_reg;
                    if (op_reg == OP_TICK)
                    begin
                        open_reg   <= close_reg;
                        high_reg   <= close_reg;
                        low_reg    <= close_reg;
                        volume_reg <= '0;
                    end
                    else
                    begin
                        open_reg   <= price_reg;
                        high_reg   <= price_reg;
                        low_reg    <= price_reg;
                        close_reg  <= price_reg;
                        volume_reg <= VOL_W'(size_reg);
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        skip_out_reg  <= skip_reg;
                        if (cnt_reg == fill_reg)
                        begin
                            act_out_reg   <= final_act_reg;
                            time_out_reg  <= bucket_start_reg;
                            open_out_reg  <= open_reg;
                            high_out_reg  <= high_reg;
                            low_out_reg   <= low_reg;
                            close_out_reg <= close_reg;
                            vol_out_reg   <= volume_reg;
                            last_out_reg  <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            act_out_reg   <= ACT_APPEND;
                            time_out_reg  <= cur_time_reg;
                            open_out_reg  <= flat_reg;
                            high_out_reg  <= flat_reg;
                            low_out_reg   <= flat_reg;
                            close_out_reg <= flat_reg;
                            vol_out_reg   <= '0;
                            last_out_reg  <= 1'b0;
                            cur_time_reg  <= cur_time_reg + TIME_W'(iv_eff);
                            cnt_reg       <= cnt_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = out_valid_reg;
    assign action          = act_out_reg;
    assign bucket_start_ms = time_out_reg;
    assign open_price      = open_out_reg;
    assign high_price      = high_out_reg;
    assign low_price       = low_out_reg;
    assign close_price     = close_out_reg;
    assign volume_total    = vol_out_reg;
    assign last_of_run     = last_out_reg;
    assign gap_skipped     = skip_out_reg;

    `ASSERT_IMPL(a_cnt_bound, state_reg == S_EMIT, cnt_reg <= fill_reg, "run count overrun")
    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(bucket_start_ms) && $stable(last_of_run), "stalled result changed")
    `ASSERT_NEXT(a_started_holds, started_reg, started_reg, "started cleared")
    `ASSERT_NEXT(a_bucket_mono, started_reg, bucket_start_reg >= $past(bucket_start_reg), "bucket moved back")

endmodule

[dv/ohlcv_candle_aggregator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ohlcv_candle_aggregator_test
// self-checking bench for the candle aggregator: a short scripted opening,
// then random trade and book tick streams under several bucket intervals,
// with random idling on both sides; every accepted item is folded into a
// local candle model and each result is compared field by field
// ----------------------------------------------------------------------------
module ohlcv_candle_aggregator_test;
    import ocagg_pkg::*;

    typedef struct packed {
        logic               op;
        logic [TIME_W-1:0]  t;
        logic [PRICE_W-1:0] price;
        logic [SIZE_W-1:0]  size;
    } market_evt_t;

    typedef struct packed {
        logic               action;
        logic [TIME_W-1:0]  bucket;
        logic [PRICE_W-1:0] o;
        logic [PRICE_W-1:0] h;
        logic [PRICE_W-1:0] l;
        logic [PRICE_W-1:0] c;
        logic [VOL_W-1:0]   vol;
        logic               last;
        logic               skip;
    } candle_t;

    typedef struct {
        market_evt_t ev;
        bit          typed;
        candle_t     res;
    } script_row_t;

    localparam candle_t     NO_CANDLE     = '0;
    localparam logic [63:0] VOL_CEIL      = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] TIME_CAP      = 64'h0000_0800_0000_0000;
    localparam int          SETTLE_CYCLES = 150;
    localparam int          PHASE_ITEMS   = 42;
    localparam int          N_SCRIPT      = 16;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               opcode = OP_TRADE;
    logic [TIME_W-1:0]  event_time_ms = '0;
    logic [PRICE_W-1:0] trade_price = '0;
    logic [SIZE_W-1:0]  trade_size = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               action;
    logic [TIME_W-1:0]  bucket_start_ms;
    logic [PRICE_W-1:0] open_price;
    logic [PRICE_W-1:0] high_price;
    logic [PRICE_W-1:0] low_price;
    logic [PRICE_W-1:0] close_price;
    logic [VOL_W-1:0]   volume_total;
    logic               last_of_run;
    logic               gap_skipped;

    ohlcv_candle_aggregator dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .event_time_ms   (event_time_ms),
        .trade_price     (trade_price),
        .trade_size      (trade_size),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .action          (action),
        .bucket_start_ms (bucket_start_ms),
        .open_price      (open_price),
        .high_price      (high_price),
        .low_price       (low_price),
        .close_price     (close_price),
        .volume_total    (volume_total),
        .last_of_run     (last_of_run),
        .gap_skipped     (gap_skipped)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // candle model state
    logic [IV_W-1:0]    interval_reg = IV_RESET;
    bit                 bar_started = 1'b0;
    logic [63:0]        bar_start = '0;
    logic [PRICE_W-1:0] bar_open = '0;
    logic [PRICE_W-1:0] bar_hi = '0;
    logic [PRICE_W-1:0] bar_lo = '0;
    logic [PRICE_W-1:0] bar_cl = '0;
    logic [63:0]        bar_vol = '0;
    logic [63:0]        tick_seen = '0;

    candle_t     due_candles[$];
    int          mismatches = 0;
    bit          idle_off = 1'b0;
    int          hold_left = 0;
    logic [63:0] now_ms = '0;
    script_row_t opening_script [N_SCRIPT];
    logic [31:0] interval_plan [8];

    function automatic logic [63:0] eff_interval();
        return (interval_reg == '0) ? 64'd1 : {32'd0, interval_reg};
    endfunction

    function automatic candle_t mk_candle(logic act, logic [63:0] bkt, logic [31:0] o,
                                          logic [31:0] h, logic [31:0] l, logic [31:0] c,
                                          logic [63:0] vol, logic skip);
        candle_t r;
        r.action = act;
        r.bucket = bkt[TIME_W-1:0];
        r.o = o;
        r.h = h;
        r.l = l;
        r.c = c;
        r.vol = vol[VOL_W-1:0];
        r.last = 1'b0;
        r.skip = skip;
        return r;
    endfunction

    function automatic void queue_candle(candle_t c);
        due_candles.insert(due_candles.size(), c);
    endfunction

    function automatic void open_bar(logic [63:0] bkt, logic [31:0] px, logic [63:0] vol);
        bar_started = 1'b1;
        bar_start = bkt;
        bar_open = px;
        bar_hi = px;
        bar_lo = px;
        bar_cl = px;
        bar_vol = vol;
    endfunction

    // fold one accepted item into the model and queue the candles it yields
    function automatic void fold_event(market_evt_t ev);
        logic [63:0] iv;
        logic [63:0] t;
        logic [63:0] tgt;
        logic [63:0] d;
        logic [63:0] m;
        logic [63:0] k;
        logic [63:0] sz;
        logic        skip;
        int          n0;
        iv = eff_interval();
        t = {20'd0, ev.t};
        sz = {32'd0, ev.size};
        tgt = t - (t % iv);
        skip = 1'b0;
        n0 = due_candles.size();
        if (ev.op == OP_TICK)
        begin
            if (t <= tick_seen)
                return;
            tick_seen = t;
            if (!bar_started || tgt <= bar_start)
                return;
            d = tgt - bar_start;
            m = (d + iv - 1) / iv;
            if (m > DEF_MAX_FILL)
            begin
                m = DEF_MAX_FILL;
                skip = 1'b1;
            end
            for (k = m; k > 0; k--)
                queue_candle(mk_candle(ACT_APPEND, tgt - (k - 1) * iv, bar_cl,
                                       bar_cl, bar_cl, bar_cl, '0, skip));
            open_bar(tgt, bar_cl, '0);
        end
        else if (!bar_started)
        begin
            open_bar(tgt, ev.price, sz);
            queue_candle(mk_candle(ACT_APPEND, tgt, ev.price, ev.price, ev.price,
                                   ev.price, sz, 1'b0));
        end
        else if (tgt == bar_start)
        begin
            if (ev.price > bar_hi)
                bar_hi = ev.price;
            if (ev.price < bar_lo)
                bar_lo = ev.price;
            bar_cl = ev.price;
            bar_vol = bar_vol + sz;
            if (bar_vol > VOL_CEIL)
                bar_vol = VOL_CEIL;
            queue_candle(mk_candle(ACT_REPLACE, bar_start, bar_open, bar_hi, bar_lo,
                                   bar_cl, bar_vol, 1'b0));
        end
        else if (tgt > bar_start)
        begin
            d = tgt - bar_start;
            m = (d + iv - 1) / iv - 1;
            if (m > DEF_MAX_FILL)
            begin
                m = DEF_MAX_FILL;
                skip = 1'b1;
            end
            for (k = m; k > 0; k--)
                queue_candle(mk_candle(ACT_APPEND, tgt - k * iv, bar_cl, bar_cl,
                                       bar_cl, bar_cl, '0, skip));
            open_bar(tgt, ev.price, sz);
            queue_candle(mk_candle(ACT_APPEND, tgt, ev.price, ev.price, ev.price,
                                   ev.price, sz, skip));
        end
        else
            return;
        if (due_candles.size() > n0)
            due_candles[due_candles.size() - 1].last = 1'b1;
    endfunction

    function automatic void match_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        candle_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (due_candles.size() == 0)
            begin
                $display("%0t ns: candle with none expected, expected nothing, got bucket %0h",
                         $time, bucket_start_ms);
                mismatches++;
            end
            else
            begin
                want = due_candles.pop_front();
                match_field("action", want.action, action);
                match_field("bucket_start_ms", want.bucket, bucket_start_ms);
                match_field("open_price", want.o, open_price);
                match_field("high_price", want.h, high_price);
                match_field("low_price", want.l, low_price);
                match_field("close_price", want.c, close_price);
                match_field("volume_total", want.vol, volume_total);
                match_field("last_of_run", want.last, last_of_run);
                match_field("gap_skipped", want.skip, gap_skipped);
            end
        end
    end

    // receiver stalls in random bursts
    always @(negedge clk)
    begin
        if (!idle_off && hold_left == 0 && $urandom_range(0, 99) < 20)
            hold_left = $urandom_range(1, 7);
        if (idle_off)
            hold_left = 0;
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic offer_event(input market_evt_t ev, input bit typed, input candle_t res);
        int n0;
        @(negedge clk);
        in_valid <= 1'b1;
        opcode <= ev.op;
        event_time_ms <= ev.t;
        trade_price <= ev.price;
        trade_size <= ev.size;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        n0 = due_candles.size();
        fold_event(ev);
        if (typed)
        begin
            while (due_candles.size() > n0)
                void'(due_candles.pop_back());
            queue_candle(res);
        end
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic drain_and_settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_candles.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_interval(input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_INTERVAL, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        interval_reg = value;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [31:0] pick_price();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r < 6)
            return bar_cl + 32'($urandom_range(0, 64)) - 32'd32;
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    // mostly a forward-moving stream: same bucket, next buckets, long gaps,
    // and a few late trades and stale ticks
    function automatic market_evt_t next_event();
        market_evt_t ev;
        logic [63:0] iv;
        logic [63:0] adv;
        logic [63:0] bkt;
        int unsigned sel;
        iv = eff_interval();
        sel = $urandom_range(0, 99);
        adv = '0;
        if (sel >= 45 && sel < 75)
            adv = 64'd1 + ({32'd0, $urandom} % (2 * iv));
        else if (sel >= 75 && sel < 88)
            adv = iv * $urandom_range(2, 6);
        else if (sel >= 88 && sel < 93)
            adv = iv * $urandom_range(60, 90);
        if (now_ms + adv < TIME_CAP)
            now_ms = now_ms + adv;
        bkt = now_ms - (now_ms % iv);
        if (sel >= 93 && bkt >= 4 * iv)
            bkt = bkt - iv * $urandom_range(1, 3);
        ev.t = 44'(bkt + ({32'd0, $urandom} % iv));
        ev.op = ($urandom_range(0, 99) < 70) ? OP_TRADE : OP_TICK;
        ev.price = pick_price();
        ev.size = pick_size();
        return ev;
    endfunction

    initial
    begin
        #(10_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        market_evt_t ev;

        // opening script at the reset interval of 60000
        opening_script[0]  = '{'{OP_TICK, 44'd0, 32'd0, 32'd0}, 1'b0, NO_CANDLE};
        opening_script[1]  = '{'{OP_TICK, 44'd1000, 32'd0, 32'd0}, 1'b0, NO_CANDLE};
        opening_script[2]  = '{'{OP_TRADE, 44'd120500, 32'd100, 32'd5}, 1'b1,
                               '{ACT_APPEND, 44'd120000, 32'd100, 32'd100, 32'd100, 32'd100,
                                 48'd5, 1'b1, 1'b0}};
        opening_script[3]  = '{'{OP_TRADE, 44'd150000, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
                               '{ACT_REPLACE, 44'd120000, 32'd100, 32'hFFFF_FFFF, 32'd100,
                                 32'hFFFF_FFFF, 48'h1_0000_0004, 1'b1, 1'b0}};
        opening_script[4]  = '{'{OP_TRADE, 44'd179999, 32'd0, 32'd0}, 1'b1,
                               '{ACT_REPLACE, 44'd120000, 32'd100, 32'hFFFF_FFFF, 32'd0,
                                 32'd0, 48'h1_0000_0004, 1'b1, 1'b0}};
        opening_script[5]  = '{'{OP_TRADE, 44'd0, 32'd55, 32'd9}, 1'b0, NO_CANDLE};
        opening_script[6]  = '{'{OP_TICK, 44'd170000, 32'd0, 32'd0}, 1'b0, NO_CANDLE};
        opening_script[7]  = '{'{OP_TICK, 44'd170000, 32'd0, 32'd0}, 1'b0, NO_CANDLE};
        opening_script[8]  = '{'{OP_TRADE, 44'd300001, 32'd7, 32'd3}, 1'b0, NO_CANDLE};
        opening_script[9]  = '{'{OP_TICK, 44'd500000, 32'd0, 32'd0}, 1'b0, NO_CANDLE};
        opening_script[10] = '{'{OP_TRADE, 44'd480001, 32'd9, 32'd1}, 1'b0, NO_CANDLE};
        opening_script[11] = '{'{OP_TRADE, 44'd6480000, 32'd12, 32'd2}, 1'b0, NO_CANDLE};
        opening_script[12] = '{'{OP_TICK, 44'd18480000, 32'd0, 32'd0}, 1'b0, NO_CANDLE};
        opening_script[13] = '{'{OP_TRADE, 44'd18660017, 32'h8000_0000, 32'h7FFF_FFFF},
                               1'b0, NO_CANDLE};
        opening_script[14] = '{'{OP_TRADE, 44'd18660018, 32'd1, 32'hFFFF_FFFF},
                               1'b0, NO_CANDLE};
        opening_script[15] = '{'{OP_TICK, 44'd18660020, 32'd0, 32'd0}, 1'b0, NO_CANDLE};

        interval_plan[0] = 32'hFFFF_FFFF;
        interval_plan[1] = 32'd1;
        interval_plan[2] = 32'd0;
        interval_plan[3] = 32'd60000;
        interval_plan[4] = $urandom_range(2, 1000);
        interval_plan[5] = $urandom_range(1001, 1 << 20);
        interval_plan[6] = $urandom;
        interval_plan[7] = 32'd250;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_SCRIPT; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 7));
            offer_event(opening_script[i].ev, opening_script[i].typed, opening_script[i].res);
        end
        now_ms = 64'd18660020;

        for (int ph = 0; ph < 8; ph++)
        begin
            drain_and_settle();
            write_interval(interval_plan[ph]);
            idle_off = (ph == 7) || ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (!idle_off && $urandom_range(0, 3) == 0)
                    pause_sender($urandom_range(1, 7));
                offer_event(next_event(), 1'b0, NO_CANDLE);
            end
        end

        // top of the time range, then scattered late trades and stale ticks
        ev = '{OP_TRADE, '1, pick_price(), pick_size()};
        offer_event(ev, 1'b0, NO_CANDLE);
        ev = '{OP_TICK, '1, 32'd0, 32'd0};
        offer_event(ev, 1'b0, NO_CANDLE);
        repeat (20)
        begin
            ev.op = ($urandom_range(0, 1) == 0) ? OP_TRADE : OP_TICK;
            ev.t = 44'({$urandom, $urandom});
            ev.price = $urandom;
            ev.size = $urandom;
            offer_event(ev, 1'b0, NO_CANDLE);
        end

        drain_and_settle();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
